[design/sdfp_pkg.sv]
// Shared types and constants for the serial display frame parser.
// No dependencies; used by sdfp_parser and the top level.
package sdfp_pkg;

    localparam int NUM_BUTTONS = 64;
    localparam int MASK_W      = 64;

    localparam logic [7:0] HDR_BYTE0 = 8'h5A;
    localparam logic [7:0] HDR_BYTE1 = 8'hA5;
    localparam logic [7:0] CMD_WRITE = 8'h82;
    localparam logic [7:0] CMD_READ  = 8'h83;
    localparam logic [15:0] PRESS_WORD = 16'h0001;

    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_POLL = 1'b1;

    typedef struct packed {
        logic        frame_done;
        logic [7:0]  command;
        logic [15:0] vp_address;
        logic        word_valid;
        logic [15:0] word_value;
        logic [6:0]  word_index;
        logic        button_valid;
        logic [15:0] button_id;
    } result_t;

endpackage

[design/serial_display_frame_parser_top.sv]
// Top level: button mask register, frame parser and output register with skid stage.
// Depends on sdfp_pkg and sdfp_parser.
//
//  channel | handshake           | payload
//  --------+---------------------+-----------------------------------------------
//  in      | in_valid / in_stall | func, rx_byte
//  out     | out_valid/out_stall | frame_done, command, vp_address, word_valid,
//          |                     | word_value, word_index, button_valid, button_id
//  cfg     | cfg_wr_en           | cfg_wr_data (button enable mask)
//
// One beat in, one beat out; a beat is taken every cycle while in_stall is low,
// and its result is registered in the output register, or in the skid stage if the
// output is stalled. The parser state updates in the same cycle. The one-entry skid
// stage absorbs a single stalled result; in_stall rises only while that stage is full.
// Reset clears the parser to hunting and sets the mask to all ones.
module serial_display_frame_parser_top
    import sdfp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              func,
    input  logic [7:0]        rx_byte,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              frame_done,
    output logic [7:0]        command,
    output logic [15:0]       vp_address,
    output logic              word_valid,
    output logic [15:0]       word_value,
    output logic [6:0]        word_index,
    output logic              button_valid,
    output logic [15:0]       button_id,
    input  logic              cfg_wr_en,
    input  logic [MASK_W-1:0] cfg_wr_data
);

    logic [MASK_W-1:0] mask_reg;
    result_t           res;
    result_t           out_res_reg;
    result_t           skid_res_reg;
    logic              out_valid_reg;
    logic              skid_valid_reg;
    logic              accept;
    logic              out_free;

    assign in_stall = skid_valid_reg;
    assign accept   = in_valid && !skid_valid_reg;
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mask_reg <= '1;
        else if (cfg_wr_en)
            mask_reg <= cfg_wr_data;
    end

    sdfp_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (accept),
        .func        (func),
        .rx_byte     (rx_byte),
        .button_mask (mask_reg),
        .res         (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_free)
            begin
                // Drain the skid entry first, else take the new beat.
                if (skid_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= accept;
                end
            end
            else if (accept)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
            out_res_reg <= skid_valid_reg ? skid_res_reg : res;
        if (!out_free && accept)
            skid_res_reg <= res;
    end

    assign out_valid    = out_valid_reg;
    assign frame_done   = out_res_reg.frame_done;
    assign command      = out_res_reg.command;
    assign vp_address   = out_res_reg.vp_address;
    assign word_valid   = out_res_reg.word_valid;
    assign word_value   = out_res_reg.word_value;
    assign word_index   = out_res_reg.word_index;
    assign button_valid = out_res_reg.button_valid;
    assign button_id    = out_res_reg.button_id;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with empty output register");

    a_press_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_res_reg.button_valid) |->
            (out_res_reg.frame_done && !out_res_reg.word_valid
             && out_res_reg.button_id == out_res_reg.vp_address))
        else $error("button press reported outside a frame end");

    a_idle_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_res_reg.word_valid) |->
            (out_res_reg.word_value == 16'd0 && out_res_reg.word_index == 7'd0))
        else $error("word fields set without a completed word");

    a_skid_from_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && out_stall))
        else $error("skid stage filled while output was free");

endmodule

[design/sdfp_parser.sv]
// Frame parser state and next-state logic; result is combinational.
// Depends on sdfp_pkg.
module sdfp_parser
    import sdfp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic              func,
    input  logic [7:0]        rx_byte,
    input  logic [MASK_W-1:0] button_mask,
    output result_t           res
);

    typedef enum logic [3:0] {
        PH_HUNT0, PH_HUNT1, PH_LEN, PH_CMD, PH_ADDR_H,
        PH_ADDR_L, PH_WLEN, PH_DATA_H, PH_DATA_L, PH_END
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  length_reg, length_next;
    logic [7:0]  bcount_reg, bcount_next;
    logic [7:0]  cmd_reg, cmd_next;
    logic [15:0] addr_reg, addr_next;
    logic [7:0]  wlimit_reg, wlimit_next;
    logic [7:0]  wcount_reg, wcount_next;
    logic [7:0]  hold_reg, hold_next;
    logic [15:0] first_reg, first_next;
    logic        armed_reg, armed_next;

    logic [7:0] bc_inc;
    logic [7:0] wc_inc;
    logic       len_hit;
    logic       btn_en;

    assign bc_inc  = bcount_reg + 8'd1;
    assign wc_inc  = wcount_reg + 8'd1;
    assign len_hit = bc_inc >= length_reg;
    // Addresses whose low byte is past the mask or the button count read as disabled; the high byte is not checked.
    assign btn_en  = (addr_reg[7:0] < 8'(NUM_BUTTONS)) && (addr_reg[7:0] < 8'(MASK_W))
                     && button_mask[addr_reg[5:0]];

    always_comb
    begin
        phase_next  = phase_reg;
        length_next = length_reg;
        bcount_next = bcount_reg;
        cmd_next    = cmd_reg;
        addr_next   = addr_reg;
        wlimit_next = wlimit_reg;
        wcount_next = wcount_reg;
        hold_next   = hold_reg;
        first_next  = first_reg;
        armed_next  = armed_reg;
        res         = '0;

        if (func == FUNC_BYTE)
        begin
            case (phase_reg)
                PH_HUNT0:
                    phase_next = (rx_byte == HDR_BYTE0) ? PH_HUNT1 : PH_HUNT0;
                PH_HUNT1:
                    phase_next = (rx_byte == HDR_BYTE1) ? PH_LEN : PH_HUNT0;
                PH_LEN:
                begin
                    bcount_next = '0;
                    length_next = rx_byte;
                    phase_next  = PH_CMD;
                end
                PH_CMD:
                begin
                    cmd_next    = rx_byte;
                    bcount_next = bc_inc;
                    if (rx_byte == CMD_READ || rx_byte == CMD_WRITE)
                    begin
                        phase_next  = PH_ADDR_H;
                        wcount_next = '0;
                    end
                    else
                    begin
                        phase_next = PH_END;
                    end
                end
                PH_ADDR_H:
                begin
                    addr_next   = {rx_byte, 8'h00};
                    bcount_next = bc_inc;
                    phase_next  = len_hit ? PH_END : PH_ADDR_L;
                end
                PH_ADDR_L:
                begin
                    addr_next   = {addr_reg[15:8], rx_byte};
                    bcount_next = bc_inc;
                    if (len_hit)
                        phase_next = PH_END;
                    else if (cmd_reg == CMD_READ)
                        phase_next = PH_WLEN;
                    else
                        phase_next = PH_DATA_H;
                end
                PH_WLEN:
                begin
                    wlimit_next = rx_byte;
                    bcount_next = bc_inc;
                    phase_next  = len_hit ? PH_END : PH_DATA_H;
                end
                PH_DATA_H:
                begin
                    hold_next   = rx_byte;
                    if (wcount_reg == 8'd0)
                        first_next = {rx_byte, 8'h00};
                    bcount_next = bc_inc;
                    phase_next  = len_hit ? PH_END : PH_DATA_L;
                end
                PH_DATA_L:
                begin
                    res.word_valid = 1'b1;
                    res.word_value = {hold_reg, rx_byte};
                    res.word_index = wcount_reg[6:0];
                    if (wcount_reg == 8'd0)
                        first_next = {first_reg[15:8], rx_byte};
                    wcount_next = wc_inc;
                    bcount_next = bc_inc;
                    // Write frames end only on the length byte.
                    if ((cmd_reg != CMD_WRITE && wc_inc >= wlimit_reg) || len_hit)
                        phase_next = PH_END;
                    else
                        phase_next = PH_DATA_H;
                end
                default:
                    phase_next = PH_END;
            endcase

            if (phase_next == PH_END)
            begin
                res.frame_done = 1'b1;
                if (cmd_next == CMD_WRITE)
                begin
                    phase_next = PH_HUNT0;
                    armed_next = 1'b1;
                end
            end
        end
        else
        begin
            if (phase_reg == PH_END)
            begin
                if (btn_en && armed_reg && first_reg == PRESS_WORD)
                begin
                    armed_next       = 1'b0;
                    res.button_valid = 1'b1;
                    res.button_id    = addr_reg;
                end
                else
                begin
                    phase_next = PH_HUNT0;
                end
            end
            res.frame_done = (phase_next == PH_END);
        end

        res.command    = cmd_next;
        res.vp_address = addr_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT0;
            length_reg <= '0;
            bcount_reg <= '0;
            cmd_reg    <= '0;
            addr_reg   <= '0;
            wlimit_reg <= '0;
            wcount_reg <= '0;
            hold_reg   <= '0;
            first_reg  <= '0;
            armed_reg  <= 1'b1;
        end
        else if (advance)
        begin
            phase_reg  <= phase_next;
            length_reg <= length_next;
            bcount_reg <= bcount_next;
            cmd_reg    <= cmd_next;
            addr_reg   <= addr_next;
            wlimit_reg <= wlimit_next;
            wcount_reg <= wcount_next;
            hold_reg   <= hold_next;
            first_reg  <= first_next;
            armed_reg  <= armed_next;
        end
    end

endmodule
